[hw/rtl/hcbp_pkg.sv]
package hcbp_pkg;

    // Item function codes carried in the input tuser.
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } func_t;

    // Field widths of the input and output items.
    localparam int SYM_W     = 8;
    localparam int WORD_W    = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int VBITS_W   = 4;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // Bit positions of the fields inside the input tdata.
    localparam int SYM_LSB  = 0;
    localparam int WORD_LSB = SYM_LSB + SYM_W;
    localparam int LEN_LSB  = WORD_LSB + WORD_W;

    // Packer accumulator: one pending byte followed by a full code word.
    localparam int ACC_W   = BYTE_W + WORD_W;
    localparam int TOTAL_W = 6;

    // Command queue between the table front end and the packer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One command for the packer: a flush, or a code word to append.
    typedef struct packed {
        logic              flush;
        logic [WORD_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } cmd_t;

endpackage

[hw/rtl/hcbp_front.sv]
module hcbp_front #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // symbol [7:0], code_bits [39:8], code_length [45:40], zero padding above
    input  logic [hcbp_pkg::S_TDATA_W-1:0]  s_tdata,
    // func [1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output hcbp_pkg::cmd_t                  cmd
);
    import hcbp_pkg::*;

    localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_LIM = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;

    // Code table storage; lengths carry a valid bit so reset means no code.
    logic [WORD_W-1:0] code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
    logic              len_vld_reg [SYMBOL_COUNT];

    // Lookup stage holding one item that waits to enter the queue.
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_flush_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic [LEN_W-1:0]  rd_len_reg;
    logic              rd_vld_reg;

    logic [SYM_W-1:0]  sym;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len_in;
    logic [LEN_W-1:0]  len_clamped;
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic              accept;
    logic              do_load;
    logic              do_lookup;
    logic              do_flush;
    logic              keep;
    logic              advance;

    // Field extraction and classification of the incoming item.
    always_comb
    begin
        sym         = s_tdata[SYM_LSB +: SYM_W];
        word        = s_tdata[WORD_LSB +: WORD_W];
        len_in      = s_tdata[LEN_LSB +: LEN_W];
        idx         = sym[IDX_W-1:0];
        in_range    = {1'b0, sym} < (SYM_W+1)'(SYMBOL_COUNT);
        len_clamped = (len_in > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : len_in;
        accept      = s_tvalid && s_tready;
        do_load     = 1'b0;
        do_lookup   = 1'b0;
        do_flush    = 1'b0;
        unique case (s_tuser)
            FUNC_LOAD:   do_load   = accept && in_range;
            FUNC_ENCODE: do_lookup = accept && in_range;
            FUNC_FLUSH:  do_flush  = accept;
            default:     ;
        endcase
    end

    // The lookup stage drops encodes of symbols that have no code.
    always_comb
    begin
        keep      = s1_flush_reg || (rd_vld_reg && (rd_len_reg != '0));
        cmd_valid = s1_valid_reg && keep;
        advance   = s1_valid_reg && (!keep || cmd_ready);
        s_tready  = !s1_valid_reg || advance;
        cmd.flush = s1_flush_reg;
        cmd.code  = rd_word_reg;
        cmd.len   = rd_len_reg;

        s1_valid_next = s1_valid_reg;
        if (do_lookup || do_flush)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Control state and length valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < SYMBOL_COUNT; i++)
            begin
                len_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (do_load)
            begin
                len_vld_reg[idx] <= 1'b1;
            end
        end
    end

    // Table writes and registered table reads.
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            code_mem[idx] <= word;
            len_mem[idx]  <= len_clamped;
        end
        if (do_lookup)
        begin
            rd_word_reg <= code_mem[idx];
            rd_len_reg  <= len_mem[idx];
            rd_vld_reg  <= len_vld_reg[idx];
        end
        if (do_lookup || do_flush)
        begin
            s1_flush_reg <= do_flush;
        end
    end

endmodule

[hw/rtl/hcbp_queue.sv]
module hcbp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hcbp_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output hcbp_pkg::cmd_t out_cmd
);
    import hcbp_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    // Pointer and occupancy update.
    always_comb
    begin
        in_ready    = count_reg != QCNT_W'(QUEUE_DEPTH);
        out_valid   = count_reg != '0;
        out_cmd     = slot_reg[rd_ptr_reg];
        push        = in_valid && in_ready;
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[hw/rtl/hcbp_packer.sv]
module hcbp_packer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  hcbp_pkg::cmd_t                 cmd,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_byte [7:0], valid_bits [11:8], zero padding above
    output logic [hcbp_pkg::M_TDATA_W-1:0] m_tdata,
    // last
    output logic                           m_tlast
);
    import hcbp_pkg::*;

    // The top byte of the accumulator is the pending byte; total counts its bits.
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic [VBITS_W-1:0] valid_bits_reg, valid_bits_next;
    logic               last_reg, last_next;
    logic               load_out;

    logic               out_free;
    logic               emitting;
    logic               pop;
    logic [WORD_W-1:0]  code_al;
    logic [LEN_W-1:0]   shamt;

    always_comb
    begin
        m_tvalid = m_valid_reg;
        m_tdata  = {(M_TDATA_W-BYTE_W-VBITS_W)'(0), valid_bits_reg, out_byte_reg};
        m_tlast  = last_reg;
    end

    // Packing: append one code word per encode command, then drain whole bytes; a flush sends the partial byte.
    always_comb
    begin
        out_free  = !m_valid_reg || m_tready;
        emitting  = total_reg >= TOTAL_W'(BYTE_W);
        cmd_ready = !emitting && (out_free || !cmd.flush);
        pop       = cmd_valid && cmd_ready;
        shamt     = LEN_W'(WORD_W) - cmd.len;
        code_al   = cmd.code << shamt;

        acc_next        = acc_reg;
        total_next      = total_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_byte_next   = out_byte_reg;
        valid_bits_next = valid_bits_reg;
        last_next       = last_reg;
        load_out        = 1'b0;

        if (emitting && out_free)
        begin
            // A full byte leaves; it is the last one when fewer than 8 bits remain.
            load_out        = 1'b1;
            m_valid_next    = 1'b1;
            out_byte_next   = acc_reg[ACC_W-1 -: BYTE_W];
            valid_bits_next = VBITS_W'(BYTE_W);
            last_next       = total_reg < TOTAL_W'(2*BYTE_W);
            acc_next        = acc_reg << BYTE_W;
            total_next      = total_reg - TOTAL_W'(BYTE_W);
        end
        else if (pop)
        begin
            if (cmd.flush)
            begin
                // A partial byte goes out zero-padded; nothing goes out when empty.
                if (total_reg[2:0] != '0)
                begin
                    load_out        = 1'b1;
                    m_valid_next    = 1'b1;
                    out_byte_next   = acc_reg[ACC_W-1 -: BYTE_W];
                    valid_bits_next = VBITS_W'(total_reg[2:0]);
                    last_next       = 1'b1;
                end
                acc_next   = '0;
                total_next = '0;
            end
            else
            begin
                acc_next   = {acc_reg[ACC_W-1 -: BYTE_W], WORD_W'(0)}
                           | ({code_al, BYTE_W'(0)} >> total_reg[2:0]);
                total_next = total_reg + TOTAL_W'(cmd.len);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg   <= out_byte_next;
            valid_bits_reg <= valid_bits_next;
            last_reg       <= last_next;
        end
    end

endmodule

[hw/rtl/huffman_code_bit_packer.sv]
// Table-driven Huffman encoder with an MSB-first byte packer. A load item
// (tuser 0) writes a symbol's code word and length into the code table; an
// encode item (tuser 1) appends that symbol's code to the pending byte and
// sends out every byte that fills; a flush item (tuser 2) sends the partial
// byte, zero-padded at the low end, with valid_bits giving its bit count.
// The input side takes one item per cycle while the lookup stage can pass its
// item on: loads finish at once, while encodes and flushes pass a registered
// table lookup into a four-entry command queue. The packer takes one command
// at a time and sends every full byte before it takes the next; a flush sends
// its partial byte as it is taken. The single output register sets the byte
// rate at one per cycle while the receiver is ready. tlast marks the final
// byte of each item.
module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // symbol [7:0], code_bits [39:8], code_length [45:40], zero padding above
    input  logic [hcbp_pkg::S_TDATA_W-1:0] s_tdata,
    // func [1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_byte [7:0], valid_bits [11:8], zero padding above
    output logic [hcbp_pkg::M_TDATA_W-1:0] m_tdata,
    // last
    output logic                           m_tlast
);
    import hcbp_pkg::*;

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qp_valid;
    logic qp_ready;
    cmd_t qp_cmd;

    hcbp_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    hcbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qp_valid),
        .out_ready (qp_ready),
        .out_cmd   (qp_cmd)
    );

    hcbp_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qp_valid),
        .cmd_ready (qp_ready),
        .cmd       (qp_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[tb/sv/huffman_code_bit_packer_tb.sv]
`timescale 1ns / 100ps

module huffman_code_bit_packer_tb;
    import hcbp_pkg::*;

    // The unused function code; the block must ignore items that carry it.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int POOL_SIZE     = 12;
    localparam int SETTLE_CYCLES = 40;

    // One packed byte as the block should send it.
    typedef struct packed {
        logic [7:0] data;
        logic [3:0] nbits;
        logic       last;
    } byte_rec_t;

    // One row of the directed table; typed rows carry their own result.
    typedef struct {
        logic [1:0]  fn;
        logic [7:0]  sym;
        logic [31:0] word;
        logic [5:0]  len;
        bit          typed;
        int          exp_n;
        byte_rec_t   exp0;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = 2'd0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Predictor state: the code table and the pending partial byte.
    logic [31:0] code_word_tbl [256];
    logic [5:0]  code_len_tbl [256];
    logic [7:0]  pend_byte;
    logic [2:0]  pend_cnt;
    byte_rec_t   pred_out [4];
    int          pred_n;

    // Bytes still owed by the block, oldest first.
    byte_rec_t   packed_byte_q [$];
    stim_row_t   dir_table [$];

    int errors = 0;
    int bytes_checked = 0;
    int items_sent = 0;
    int loads_sent = 0;
    int encodes_sent = 0;
    int flushes_sent = 0;
    int ignored_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;

    // Receiver stall pattern state.
    int         rx_mode = 0;
    int         rx_left = 0;
    logic [7:0] rx_tick = 8'd0;

    huffman_code_bit_packer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Work out the bytes one accepted item produces and update the packer state.
    task automatic predict_packed_bytes(input logic [1:0] fn, input logic [7:0] sym,
                                        input logic [31:0] word, input logic [5:0] len);
        int i;
        int cnt;
        int clen;
        pred_n = 0;
        case (fn)
            FUNC_LOAD:
            begin
                code_word_tbl[sym] = word;
                code_len_tbl[sym] = (len > 6'd32) ? 6'd32 : len;
            end
            FUNC_ENCODE:
            begin
                clen = int'(code_len_tbl[sym]);
                cnt = int'(pend_cnt);
                for (i = clen; i > 0; i--)
                begin
                    if (code_word_tbl[sym][i-1])
                        pend_byte[7-cnt] = 1'b1;
                    cnt++;
                    if (cnt == 8)
                    begin
                        pred_out[pred_n] = '{data: pend_byte, nbits: 4'd8, last: 1'b0};
                        pred_n++;
                        pend_byte = 8'd0;
                        cnt = 0;
                    end
                end
                pend_cnt = cnt[2:0];
                if (pred_n > 0)
                    pred_out[pred_n-1].last = 1'b1;
            end
            FUNC_FLUSH:
            begin
                if (pend_cnt != 3'd0)
                begin
                    pred_out[0] = '{data: pend_byte, nbits: {1'b0, pend_cnt}, last: 1'b1};
                    pred_n = 1;
                    pend_byte = 8'd0;
                    pend_cnt = 3'd0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic add_row(input logic [1:0] fn, input logic [7:0] sym,
                           input logic [31:0] word, input logic [5:0] len,
                           input bit typed, input int exp_n,
                           input logic [7:0] exp_data, input logic [3:0] exp_nbits);
        stim_row_t row;
        row.fn = fn;
        row.sym = sym;
        row.word = word;
        row.len = len;
        row.typed = typed;
        row.exp_n = exp_n;
        row.exp0 = '{data: exp_data, nbits: exp_nbits, last: 1'b1};
        dir_table.push_back(row);
    endtask

    // Open a gap between bursts when the current burst is used up.
    task automatic sender_gap();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            if ($urandom_range(0, 9) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Present one item, wait for it to be taken, then record what it owes.
    task automatic send_item(input logic [1:0] fn, input logic [7:0] sym,
                             input logic [31:0] word, input logic [5:0] len,
                             input bit typed, input int exp_n, input byte_rec_t exp0);
        int k;
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {{(S_TDATA_W - SYM_W - WORD_W - LEN_W){1'b0}}, len, word, sym};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_packed_bytes(fn, sym, word, len);
        if (typed)
        begin
            if (exp_n > 0)
                packed_byte_q.push_back(exp0);
        end
        else
        begin
            for (k = 0; k < pred_n; k++)
                packed_byte_q.push_back(pred_out[k]);
        end
        items_sent++;
        case (fn)
            FUNC_LOAD:   loads_sent++;
            FUNC_ENCODE: encodes_sent++;
            FUNC_FLUSH:  flushes_sent++;
            default:     ignored_sent++;
        endcase
    endtask

    // Hold the sender off until every owed byte has come out.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (packed_byte_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: switch between always ready, random, periodic and heavy stalls.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(32, 200);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 8'd1;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_tick[1:0] == 2'd0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each accepted byte with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (packed_byte_q.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, got out_byte %h valid_bits %0d last %0d",
                         $time, m_tdata[7:0], m_tdata[11:8], m_tlast);
                errors++;
            end
            else
            begin
                if (m_tdata[7:0] !== packed_byte_q[0].data)
                begin
                    $display("%0t: out_byte mismatch, expected %h, got %h",
                             $time, packed_byte_q[0].data, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[11:8] !== packed_byte_q[0].nbits)
                begin
                    $display("%0t: valid_bits mismatch, expected %0d, got %0d",
                             $time, packed_byte_q[0].nbits, m_tdata[11:8]);
                    errors++;
                end
                if (m_tlast !== packed_byte_q[0].last)
                begin
                    $display("%0t: last mismatch, expected %0d, got %0d",
                             $time, packed_byte_q[0].last, m_tlast);
                    errors++;
                end
                void'(packed_byte_q.pop_front());
                bytes_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d bytes still owed",
                 cycle_count, packed_byte_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus: directed table first, then random traffic.
    initial
    begin
        int n;
        int r;
        int lsel;
        logic [1:0]  fn;
        logic [7:0]  sym;
        logic [31:0] word;
        logic [5:0]  len;
        logic [7:0]  sym_pool [POOL_SIZE];
        byte_rec_t   no_rec;

        no_rec = '0;
        for (n = 0; n < 256; n++)
        begin
            code_word_tbl[n] = 32'd0;
            code_len_tbl[n] = 6'd0;
        end
        pend_byte = 8'd0;
        pend_cnt = 3'd0;
        for (n = 0; n < POOL_SIZE; n++)
            sym_pool[n] = 8'($urandom_range(0, 255));

        // Empty flush, empty-table encode and an ignored item straight after reset.
        add_row(FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1, 0, 8'h00, 4'd0);
        add_row(FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1, 0, 8'h00, 4'd0);
        add_row(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1, 0, 8'h00, 4'd0);
        // A plain one-byte code.
        add_row(FUNC_LOAD,   8'h00, 32'h0000_00A5, 6'd8,  1, 0, 8'h00, 4'd0);
        add_row(FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1, 1, 8'hA5, 4'd8);
        // The longest code, all ones.
        add_row(FUNC_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 1, 0, 8'h00, 4'd0);
        add_row(FUNC_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  0, 0, 8'h00, 4'd0);
        // Short code with junk above its length, then a partial flush.
        add_row(FUNC_LOAD,   8'h01, 32'hDEAD_BEE5, 6'd3,  1, 0, 8'h00, 4'd0);
        add_row(FUNC_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1, 0, 8'h00, 4'd0);
        add_row(FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1, 1, 8'hA0, 4'd3);
        add_row(FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1, 0, 8'h00, 4'd0);
        // Overlong length saturates to a 32-bit run of zeros.
        add_row(FUNC_LOAD,   8'h80, 32'h0000_0000, 6'd63, 1, 0, 8'h00, 4'd0);
        add_row(FUNC_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  0, 0, 8'h00, 4'd0);
        add_row(FUNC_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  0, 0, 8'h00, 4'd0);
        add_row(FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  0, 0, 8'h00, 4'd0);
        // Seven pending bits plus a full word: four bytes and a 7-bit flush.
        add_row(FUNC_LOAD,   8'h03, 32'h0000_007F, 6'd7,  1, 0, 8'h00, 4'd0);
        add_row(FUNC_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1, 0, 8'h00, 4'd0);
        add_row(FUNC_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  0, 0, 8'h00, 4'd0);
        add_row(FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  0, 0, 8'h00, 4'd0);
        // Reloading a symbol with length zero removes its code.
        add_row(FUNC_LOAD,   8'h00, 32'h1234_5678, 6'd0,  1, 0, 8'h00, 4'd0);
        add_row(FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1, 0, 8'h00, 4'd0);
        // Length just past the limit, then an ignored item and an empty flush.
        add_row(FUNC_LOAD,   8'h55, 32'hAAAA_AAAA, 6'd33, 1, 0, 8'h00, 4'd0);
        add_row(FUNC_ENCODE, 8'h55, 32'h0000_0000, 6'd0,  0, 0, 8'h00, 4'd0);
        add_row(FUNC_UNUSED, 8'h00, 32'h0000_0000, 6'd0,  1, 0, 8'h00, 4'd0);
        add_row(FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1, 0, 8'h00, 4'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
        begin
            sender_gap();
            send_item(dir_table[i].fn, dir_table[i].sym, dir_table[i].word,
                      dir_table[i].len, dir_table[i].typed, dir_table[i].exp_n,
                      dir_table[i].exp0);
        end
        drain_outputs();

        // Random traffic: mostly encodes of a small set of loaded symbols.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            word = $urandom;
            lsel = $urandom_range(0, 99);
            if (lsel < 10)
                len = 6'd0;
            else if (lsel < 60)
                len = 6'($urandom_range(1, 8));
            else if (lsel < 85)
                len = 6'($urandom_range(9, 16));
            else if (lsel < 95)
                len = 6'($urandom_range(17, 32));
            else
                len = 6'($urandom_range(33, 63));
            if (r < 15)
            begin
                fn = FUNC_LOAD;
                sym = ($urandom_range(0, 1) == 0) ? sym_pool[$urandom_range(0, POOL_SIZE-1)]
                                                   : 8'($urandom_range(0, 255));
            end
            else if (r < 80)
            begin
                fn = FUNC_ENCODE;
                sym = ($urandom_range(0, 4) != 0) ? sym_pool[$urandom_range(0, POOL_SIZE-1)]
                                                   : 8'($urandom_range(0, 255));
            end
            else if (r < 92)
            begin
                fn = FUNC_FLUSH;
                sym = 8'($urandom_range(0, 255));
            end
            else
            begin
                fn = FUNC_UNUSED;
                sym = 8'($urandom_range(0, 255));
            end
            sender_gap();
            send_item(fn, sym, word, len, 0, 0, no_rec);
            if (n == RANDOM_ITEMS / 2)
                drain_outputs();
        end

        // Let everything owed come out, then give the block time for strays.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (packed_byte_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d directed): %0d loads, %0d encodes, %0d flushes, %0d ignored",
                 items_sent, dir_table.size(), loads_sent, encodes_sent, flushes_sent,
                 ignored_sent);
        $display("Checked %0d packed bytes in %0d cycles, %0d errors",
                 bytes_checked, cycle_count, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
